// File: sv/dongle_keyed_round_sequencer_top_assert.svh
// Assertion macros shared by the keyed round sequencer modules.
`ifndef DONGLE_KEYED_ROUND_SEQUENCER_TOP_ASSERT_SVH
`define DONGLE_KEYED_ROUND_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DKRS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("keyed round sequencer same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DKRS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("keyed round sequencer next-cycle check failed");

`endif

// File: sv/dkrs_pkg.sv
// Package with the types, codes and byte encoders of the keyed round sequencer.
package dkrs_pkg;

	localparam int ANSWERS_PER_ROUND = 40;
	localparam int CAPTURE_BITS = 40;
	localparam int ANS_CNT_W = $clog2(ANSWERS_PER_ROUND);
	localparam int BIT_POS_W = $clog2(CAPTURE_BITS) + 1;
	localparam logic [31:0] POLY_VALUE = 32'h8050_0062;

	localparam logic [7:0] CMD_KEY = 8'h4E;
	localparam logic [7:0] RAW_SELECT = 8'h84;

	// Input opcodes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_ANSWER = 1'b1;

	// Result kinds.
	localparam logic [1:0] RK_WRITE = 2'd0;
	localparam logic [1:0] RK_FINISHED = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;

	// Job kinds passed from front to back.
	localparam logic [1:0] JOB_START = 2'd0;
	localparam logic [1:0] JOB_QUERY = 2'd1;
	localparam logic [1:0] JOB_FINISH = 2'd2;
	localparam logic [1:0] JOB_ERROR = 2'd3;

	// Words per job and the step counter that walks them.
	localparam int START_WORDS = 10;
	localparam int QUERY_WORDS = 3;
	localparam int STEP_W = $clog2(START_WORDS);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0]              kind;
		logic [7:0]              seed;
		logic [7:0]              query;
		logic [31:0]             value;
		logic [CAPTURE_BITS-1:0] capture;
	} job_t;

	// One of the three writes that send a command byte.
	function automatic logic [7:0] cmd_byte(input logic [7:0] b, input logic mid);
		logic [7:0] r;
		if (mid) begin
			r = b | 8'h81;
		end else begin
			r = (b & 8'hFE) | 8'h80;
		end
		return r;
	endfunction

	// One of the three writes that query a byte; the middle one raises the strobe.
	function automatic logic [7:0] query_byte(input logic [7:0] q, input logic mid);
		logic [7:0] p;
		p = ((q << 1) & 8'h0E) | ((q << 2) & 8'h60) | 8'h80;
		if (mid) begin
			p = p | 8'h10;
		end
		return p;
	endfunction

endpackage

// File: sv/dkrs_front.sv
// Front end: accepts input words, keeps the round state and issues jobs.
module dkrs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                in_valid,
	input  logic                in_opcode,
	input  logic [31:0]         in_value,
	input  logic                in_answer,
	input  logic                q_full,
	output logic                in_ready,
	output logic                q_push,
	output dkrs_pkg::job_t      q_job
);
	import dkrs_pkg::*;

	logic [7:0]              seed_q;
	logic [31:0]             shift_q;
	logic [ANS_CNT_W-1:0]    cnt_q;
	logic                    busy_q;
	logic [CAPTURE_BITS-1:0] cap_q;

	logic                    accept;
	logic [BIT_POS_W-1:0]    cnt_ext;
	logic [BIT_POS_W-1:0]    bit_pos;
	logic [CAPTURE_BITS-1:0] cap_new;
	logic [31:0]             shift_new;
	logic [1:0]              sel;
	logic [7:0]              sel_byte;
	logic                    last_answer;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign q_push = accept;

	always_comb begin
		cnt_ext = BIT_POS_W'(cnt_q);
		bit_pos = BIT_POS_W'(CAPTURE_BITS - 1) - cnt_ext;
		if (cnt_ext < BIT_POS_W'(CAPTURE_BITS)) begin
			cap_new = cap_q | (CAPTURE_BITS'(in_answer) << bit_pos);
		end else begin
			cap_new = cap_q;
		end
		if (in_answer ^ shift_q[0]) begin
			shift_new = (shift_q >> 1) ^ POLY_VALUE;
		end else begin
			shift_new = shift_q >> 1;
		end
		sel = {shift_q[0], in_answer};
		case (sel)
			2'd0: sel_byte = shift_new[7:0];
			2'd1: sel_byte = shift_new[15:8];
			2'd2: sel_byte = shift_new[23:16];
			2'd3: sel_byte = shift_new[31:24];
			default: sel_byte = shift_new[7:0];
		endcase
		last_answer = cnt_q >= ANS_CNT_W'(ANSWERS_PER_ROUND - 1);
	end

	always_comb begin
		q_job = '0;
		case (in_opcode)
			OP_START: begin
				if (busy_q) begin
					q_job.kind = JOB_ERROR;
				end else begin
					q_job.kind = JOB_START;
					q_job.seed = seed_q;
					q_job.query = in_value[7:0];
				end
			end
			OP_ANSWER: begin
				if (!busy_q) begin
					q_job.kind = JOB_ERROR;
				end else if (last_answer) begin
					q_job.kind = JOB_FINISH;
					q_job.value = shift_q;
					q_job.capture = cap_new;
				end else begin
					q_job.kind = JOB_QUERY;
					q_job.query = sel_byte;
				end
			end
			default: q_job.kind = JOB_ERROR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			shift_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			cap_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (accept) begin
				if (in_opcode == OP_START) begin
					if (!busy_q) begin
						shift_q <= in_value;
						cnt_q <= '0;
						cap_q <= '0;
						busy_q <= 1'b1;
					end
				end else if (busy_q) begin
					cap_q <= cap_new;
					if (last_answer) begin
						busy_q <= 1'b0;
						cnt_q <= '0;
					end else begin
						shift_q <= shift_new;
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// File: sv/dkrs_queue.sv
// Short job queue between the front end and the word generator.
`include "dongle_keyed_round_sequencer_top_assert.svh"

module dkrs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dkrs_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output dkrs_pkg::job_t head_job
);
	import dkrs_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = count_q == QCNT_W'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`DKRS_ASSERT_NOW(a_no_overflow, push, !full || pop)
	`DKRS_ASSERT_NOW(a_pop_has_entry, pop, head_valid)
	`DKRS_ASSERT_NEXT(a_count_grows, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// File: sv/dkrs_back.sv
// Back end: expands queued jobs into result words behind an output register.
`include "dongle_keyed_round_sequencer_top_assert.svh"

module dkrs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  dkrs_pkg::job_t               head_job,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   out_kind,
	output logic [7:0]                   out_byte,
	output logic [31:0]                  out_value,
	output logic [dkrs_pkg::CAPTURE_BITS-1:0] out_capture,
	output logic                         out_last
);
	import dkrs_pkg::*;

	logic [STEP_W-1:0]       step_q;
	logic                    valid_q;
	logic [1:0]              kind_q;
	logic [7:0]              byte_q;
	logic [31:0]             value_q;
	logic [CAPTURE_BITS-1:0] capture_q;
	logic                    last_q;

	logic                    load;
	logic                    last_step;
	logic [1:0]              w_kind;
	logic [7:0]              w_byte;
	logic [31:0]             w_value;
	logic [CAPTURE_BITS-1:0] w_capture;

	assign load = head_valid && (!valid_q || out_ready);
	assign pop = load && last_step;

	always_comb begin
		w_kind = RK_WRITE;
		w_byte = '0;
		w_value = '0;
		w_capture = '0;
		last_step = 1'b1;
		case (head_job.kind)
			JOB_START: begin
				last_step = step_q == STEP_W'(START_WORDS - 1);
				if (step_q < STEP_W'(3)) begin
					w_byte = cmd_byte(head_job.seed, step_q == STEP_W'(1));
				end else if (step_q < STEP_W'(6)) begin
					w_byte = cmd_byte(CMD_KEY, step_q == STEP_W'(4));
				end else if (step_q == STEP_W'(6)) begin
					w_byte = RAW_SELECT;
				end else begin
					w_byte = query_byte(head_job.query, step_q == STEP_W'(8));
				end
			end
			JOB_QUERY: begin
				last_step = step_q == STEP_W'(QUERY_WORDS - 1);
				w_byte = query_byte(head_job.query, step_q == STEP_W'(1));
			end
			JOB_FINISH: begin
				w_kind = RK_FINISHED;
				w_value = head_job.value;
				w_capture = head_job.capture;
			end
			JOB_ERROR: begin
				w_kind = RK_ERROR;
			end
			default: begin
				w_kind = RK_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				if (last_step) begin
					step_q <= '0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= w_kind;
			byte_q <= w_byte;
			value_q <= w_value;
			capture_q <= w_capture;
			last_q <= last_step;
		end
	end

	assign out_valid = valid_q;
	assign out_kind = kind_q;
	assign out_byte = byte_q;
	assign out_value = value_q;
	assign out_capture = capture_q;
	assign out_last = last_q;

	`DKRS_ASSERT_NOW(a_step_needs_job, step_q != '0, head_valid)
	`DKRS_ASSERT_NEXT(a_step_wraps, pop, step_q == '0)
	`DKRS_ASSERT_NOW(a_report_is_last, valid_q && (kind_q != RK_WRITE), last_q)

endmodule

// File: sv/dongle_keyed_round_sequencer_top.sv
// Top level of the keyed round sequencer: front end, job queue and word generator.
//
// The block runs one keyed round against a parallel-port dongle. A start word (tuser 0)
// loads a 32-bit value and produces ten data-port write words: the seed command, the
// 0x4E command, the raw 0x84 byte and the three writes that query the value's low byte.
// Each answer word (tuser 1) records the partner's answer bit into a 40-bit capture,
// first answer in the top bit, steps the value through its polynomial shift and
// produces the three writes that query the byte picked by the answer and the old low
// bit; the fortieth answer instead produces one round-finished word that carries the
// final value and the capture. A start during a round, or an answer outside one, gives
// one protocol-error word and leaves the state alone. The last word caused by each
// input word has tlast set. The front end takes one input word per cycle while its
// four-entry job queue has room, so input and output stall independently. The word
// generator behind the queue emits one result word per cycle while m_tready takes
// them through an output register, so it sets the sustained rate: ten words per start,
// three per answer, one per finish or error. The seed register is written through
// cfg_wr_en and cfg_wr_data, takes effect for the next start and resets to zero.
module dongle_keyed_round_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // round_input [31:0], answer_bit [32], zero pad [39:33]
	input  logic [0:0]  s_tuser,   // opcode [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // port_byte [7:0], round_output [39:8],
	                               // captured_answers [79:40]
	output logic [1:0]  m_tuser,   // result_kind [1:0]
	output logic        m_tlast    // last_of_run
);
	import dkrs_pkg::*;

	logic                    q_push;
	logic                    q_full;
	logic                    q_pop;
	logic                    q_head_valid;
	job_t                    q_job;
	job_t                    q_head;
	logic [7:0]              out_byte;
	logic [31:0]             out_value;
	logic [CAPTURE_BITS-1:0] out_capture;

	// Front end: classifies each word against the round state and queues a job.
	dkrs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_tvalid),
		.in_opcode   (s_tuser[0]),
		.in_value    (s_tdata[31:0]),
		.in_answer   (s_tdata[32]),
		.q_full      (q_full),
		.in_ready    (s_tready),
		.q_push      (q_push),
		.q_job       (q_job)
	);

	// Jobs wait here so the front end keeps accepting while results drain.
	dkrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head)
	);

	// Word generator: walks each job one result word per cycle while the output accepts words.
	dkrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_head_valid),
		.head_job    (q_head),
		.pop         (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (m_tuser),
		.out_byte    (out_byte),
		.out_value   (out_value),
		.out_capture (out_capture),
		.out_last    (m_tlast)
	);

	assign m_tdata = {out_capture, out_value, out_byte};

endmodule
